// ----- rtl/voxel_visible_face_extractor_assert.svh -----
// ----------------------------------------------------------------------------
// voxel_visible_face_extractor_assert.svh
// Assertion macros used by the face extractor checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_VISIBLE_FACE_EXTRACTOR_ASSERT_SVH
`define VOXEL_VISIBLE_FACE_EXTRACTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define VVFE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vvfe: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define VVFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vvfe: next-cycle check failed");

`endif

// ----- rtl/vvfe_pkg.sv -----
// ----------------------------------------------------------------------------
// vvfe_pkg
// Types and constants of the voxel visible face extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vvfe_pkg;

    localparam int POS_W      = 6;
    localparam int BID_W      = 16;
    localparam int FPOS_W     = 5;
    localparam int DIR_W      = 3;
    localparam int PAL_W      = 3;
    localparam int COLOR_W    = 24;
    localparam int NUM_DIRS   = 6;
    localparam int RD_CNT_W   = 3;

    // op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // face directions
    localparam logic [DIR_W-1:0] DIR_XP = 3'd0;
    localparam logic [DIR_W-1:0] DIR_XN = 3'd1;
    localparam logic [DIR_W-1:0] DIR_YP = 3'd2;
    localparam logic [DIR_W-1:0] DIR_YN = 3'd3;
    localparam logic [DIR_W-1:0] DIR_ZP = 3'd4;
    localparam logic [DIR_W-1:0] DIR_ZN = 3'd5;

    // debug colors per direction, red in the low byte
    localparam logic [COLOR_W-1:0] COLOR_XP = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COLOR_XN = 24'h00FFFF;
    localparam logic [COLOR_W-1:0] COLOR_YP = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COLOR_YN = 24'hFFFF00;
    localparam logic [COLOR_W-1:0] COLOR_ZP = 24'hFF0000;
    localparam logic [COLOR_W-1:0] COLOR_ZN = 24'hFF00FF;

    localparam logic [COLOR_W-1:0] DIR_COLOR [NUM_DIRS] = '{
        COLOR_XP, COLOR_XN, COLOR_YP, COLOR_YN, COLOR_ZP, COLOR_ZN
    };

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [BID_W-1:0] voxel_id;
    } in_word_t;

    typedef struct packed {
        logic [FPOS_W-1:0]  face_x;
        logic [FPOS_W-1:0]  face_y;
        logic [FPOS_W-1:0]  face_z;
        logic [DIR_W-1:0]   face_dir;
        logic [PAL_W-1:0]   palette_index;
        logic [COLOR_W-1:0] face_color;
        logic               last;
    } out_word_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LOAD,
        KIND_QUERY,
        KIND_CLEAR
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic latch;
        logic write;
        logic rd_en;
        logic emit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        kind_t in_kind;
        logic  rd_last;
        logic  faces_left;
        logic  last_face;
        logic  out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/vvfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// vvfe_ctrl
// Sequencer: load write, clear, seven-read neighbor scan, face record emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vvfe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  vvfe_pkg::status_t status,
    output vvfe_pkg::cmd_t    cmd
);

    vvfe_pkg::state_t state_reg;
    vvfe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vvfe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vvfe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (status.in_kind)
                        vvfe_pkg::KIND_LOAD:  state_next = vvfe_pkg::ST_WRITE;
                        vvfe_pkg::KIND_QUERY: state_next = vvfe_pkg::ST_READ;
                        default:              state_next = vvfe_pkg::ST_IDLE;
                    endcase
                end
            end
            vvfe_pkg::ST_WRITE:
            begin
                state_next = vvfe_pkg::ST_IDLE;
            end
            vvfe_pkg::ST_READ:
            begin
                if (status.rd_last)
                begin
                    state_next = vvfe_pkg::ST_DRAIN;
                end
            end
            vvfe_pkg::ST_DRAIN:
            begin
                state_next = vvfe_pkg::ST_EMIT;
            end
            vvfe_pkg::ST_EMIT:
            begin
                if (!status.faces_left)
                begin
                    state_next = vvfe_pkg::ST_IDLE;
                end
                else if (status.out_free && status.last_face)
                begin
                    state_next = vvfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vvfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        cmd       = '0;
        unique case (state_reg)
            vvfe_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
                cmd.clear = in_valid && (status.in_kind == vvfe_pkg::KIND_CLEAR);
            end
            vvfe_pkg::ST_WRITE:
            begin
                cmd.write = 1'b1;
            end
            vvfe_pkg::ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            vvfe_pkg::ST_DRAIN:
            begin
                cmd.rd_en = 1'b0;
            end
            vvfe_pkg::ST_EMIT:
            begin
                cmd.emit = status.faces_left && status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/vvfe_dp.sv -----
// ----------------------------------------------------------------------------
// vvfe_dp
// Block id store, neighbor scan, palette and output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vvfe_dp #(
    parameter int CHUNK_EDGE = 32,
    parameter int ID_BITS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vvfe_pkg::in_word_t  in_word,
    output vvfe_pkg::out_word_t out_word,
    output logic                out_valid,
    input  logic                out_stall,
    input  vvfe_pkg::cmd_t      cmd,
    output vvfe_pkg::status_t   status
);

    localparam int SIDE   = CHUNK_EDGE + 2;
    localparam int DEPTH  = SIDE * SIDE * SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = vvfe_pkg::POS_W + 1;
    localparam int ND     = vvfe_pkg::NUM_DIRS;

    localparam logic [CMP_W-1:0]  SIDE_C     = CMP_W'(SIDE);
    localparam logic [CMP_W-1:0]  EDGE_C     = CMP_W'(CHUNK_EDGE);
    localparam logic [ADDR_W-1:0] SIDE_A     = ADDR_W'(SIDE);
    localparam logic [ADDR_W-1:0] OFF_X      = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] OFF_Y      = ADDR_W'(SIDE);
    localparam logic [ADDR_W-1:0] OFF_Z      = ADDR_W'(SIDE * SIDE);
    localparam logic [ADDR_W-1:0] CENTER_OFF = ADDR_W'(1 + SIDE + SIDE * SIDE);

    // block id store, single port, registered read
    logic [ID_BITS-1:0] mem [DEPTH];

    logic [ADDR_W-1:0]                   addr_reg;
    logic [ID_BITS-1:0]                  id_reg;
    logic [vvfe_pkg::FPOS_W-1:0]         fx_reg;
    logic [vvfe_pkg::FPOS_W-1:0]         fy_reg;
    logic [vvfe_pkg::FPOS_W-1:0]         fz_reg;
    logic [ID_BITS-1:0]                  rd_data_reg;
    logic [vvfe_pkg::RD_CNT_W-1:0]       rd_idx_reg;
    logic                                rd_pend_reg;
    logic [vvfe_pkg::RD_CNT_W-1:0]       rcnt_reg;
    logic                                center_nz_reg;
    logic [ND-1:0]                       rem_reg;
    logic [ND-1:0]                       seen_reg;
    logic [vvfe_pkg::PAL_W-1:0]          slot_reg [ND];
    logic [vvfe_pkg::PAL_W-1:0]          count_reg;
    logic                                out_valid_reg;
    vvfe_pkg::out_word_t                 out_word_reg;
    vvfe_pkg::out_word_t                 out_word_next;

    logic [ADDR_W-1:0]             base_addr;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          load_ok;
    logic                          query_ok;
    vvfe_pkg::kind_t               kind;
    logic [ND-1:0]                 rem_v;
    logic [ND-1:0]                 sel_oh;
    logic [vvfe_pkg::DIR_W-1:0]    sel_dir;
    logic [vvfe_pkg::PAL_W-1:0]    pal_idx;
    logic                          out_free;

    // decode of the word at the input
    always_comb
    begin
        load_ok  = ({1'b0, in_word.pos_x} < SIDE_C) && ({1'b0, in_word.pos_y} < SIDE_C)
                && ({1'b0, in_word.pos_z} < SIDE_C);
        query_ok = ({1'b0, in_word.pos_x} < EDGE_C) && ({1'b0, in_word.pos_y} < EDGE_C)
                && ({1'b0, in_word.pos_z} < EDGE_C);
        kind     = vvfe_pkg::KIND_NONE;
        case (in_word.op)
            vvfe_pkg::OP_LOAD:  kind = load_ok ? vvfe_pkg::KIND_LOAD : vvfe_pkg::KIND_NONE;
            vvfe_pkg::OP_QUERY: kind = query_ok ? vvfe_pkg::KIND_QUERY : vvfe_pkg::KIND_NONE;
            vvfe_pkg::OP_CLEAR: kind = vvfe_pkg::KIND_CLEAR;
            default:            kind = vvfe_pkg::KIND_NONE;
        endcase
        base_addr = ADDR_W'(in_word.pos_x)
                  + SIDE_A * (ADDR_W'(in_word.pos_y) + SIDE_A * ADDR_W'(in_word.pos_z));
    end

    // scan order: center, then X+, X-, Y+, Y-, Z+, Z-
    always_comb
    begin
        case (rcnt_reg)
            3'd1:    rd_addr = addr_reg + OFF_X;
            3'd2:    rd_addr = addr_reg - OFF_X;
            3'd3:    rd_addr = addr_reg + OFF_Y;
            3'd4:    rd_addr = addr_reg - OFF_Y;
            3'd5:    rd_addr = addr_reg + OFF_Z;
            3'd6:    rd_addr = addr_reg - OFF_Z;
            default: rd_addr = addr_reg;
        endcase
    end

    // pick the lowest pending direction
    always_comb
    begin
        rem_v   = center_nz_reg ? rem_reg : '0;
        sel_oh  = rem_v & (~rem_v + ND'(1));
        sel_dir = '0;
        for (int i = 0; i < ND; i++)
        begin
            if (sel_oh[i])
            begin
                sel_dir = vvfe_pkg::DIR_W'(i);
            end
        end
        pal_idx  = seen_reg[sel_dir] ? slot_reg[sel_dir] : count_reg;
        out_free = !out_valid_reg || !out_stall;

        out_word_next.face_x        = fx_reg;
        out_word_next.face_y        = fy_reg;
        out_word_next.face_z        = fz_reg;
        out_word_next.face_dir      = sel_dir;
        out_word_next.palette_index = pal_idx;
        out_word_next.face_color    = vvfe_pkg::DIR_COLOR[sel_dir];
        out_word_next.last          = ((rem_v & ~sel_oh) == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[addr_reg] <= id_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            addr_reg <= (kind == vvfe_pkg::KIND_QUERY) ? base_addr + CENTER_OFF : base_addr;
            id_reg   <= ID_BITS'(in_word.voxel_id);
            fx_reg   <= in_word.pos_x[vvfe_pkg::FPOS_W-1:0];
            fy_reg   <= in_word.pos_y[vvfe_pkg::FPOS_W-1:0];
            fz_reg   <= in_word.pos_z[vvfe_pkg::FPOS_W-1:0];
        end
        if (cmd.rd_en)
        begin
            rd_idx_reg <= rcnt_reg;
        end
        if (cmd.emit)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            rcnt_reg      <= '0;
            center_nz_reg <= 1'b0;
            rem_reg       <= '0;
            seen_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ND; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            rd_pend_reg <= cmd.rd_en;

            if (cmd.latch)
            begin
                rcnt_reg      <= '0;
                center_nz_reg <= 1'b0;
                rem_reg       <= '0;
            end
            else if (cmd.rd_en)
            begin
                rcnt_reg <= rcnt_reg + vvfe_pkg::RD_CNT_W'(1);
            end

            // returned read: center sets nonzero flag, neighbors mark empty faces
            if (rd_pend_reg)
            begin
                if (rd_idx_reg == '0)
                begin
                    center_nz_reg <= (rd_data_reg != '0);
                end
                else
                begin
                    rem_reg[rd_idx_reg - vvfe_pkg::RD_CNT_W'(1)] <= (rd_data_reg == '0);
                end
            end

            if (cmd.emit)
            begin
                rem_reg <= rem_reg & ~sel_oh;
                if (!seen_reg[sel_dir])
                begin
                    seen_reg[sel_dir] <= 1'b1;
                    slot_reg[sel_dir] <= count_reg;
                    count_reg         <= count_reg + vvfe_pkg::PAL_W'(1);
                end
            end

            if (cmd.clear)
            begin
                seen_reg  <= '0;
                count_reg <= '0;
                for (int i = 0; i < ND; i++)
                begin
                    slot_reg[i] <= '0;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.in_kind    = kind;
        status.rd_last    = (rcnt_reg == vvfe_pkg::RD_CNT_W'(ND));
        status.faces_left = (rem_v != '0);
        status.last_face  = out_word_next.last;
        status.out_free   = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ----- rtl/voxel_visible_face_extractor.sv -----
// ----------------------------------------------------------------------------
// voxel_visible_face_extractor: exposed-face records for one voxel chunk.
// Load words write the store, clear words reset the palette, ignored words are
// dropped. A query is accepted, makes seven single-port store reads and a drain,
// then emits one record per exposed face, held while the output stalls. Async
// active-low reset clears palette and control; the store is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_visible_face_extractor #(
    parameter int CHUNK_EDGE = 32,
    parameter int ID_BITS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  vvfe_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output vvfe_pkg::out_word_t out_word
);

    vvfe_pkg::cmd_t    cmd;
    vvfe_pkg::status_t status;

    vvfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    vvfe_dp #(
        .CHUNK_EDGE (CHUNK_EDGE),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- rtl/vvfe_checker.sv -----
// ----------------------------------------------------------------------------
// vvfe_checker
// Port-level checks of the face extractor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "voxel_visible_face_extractor_assert.svh"

module vvfe_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input vvfe_pkg::in_word_t  in_word,
    input logic                out_valid,
    input logic                out_stall,
    input vvfe_pkg::out_word_t out_word
);

    `VVFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    `VVFE_ASSERT_NEXT(a_clear_ready, in_valid && !in_stall && (in_word.op == vvfe_pkg::OP_CLEAR), !in_stall)

    `VVFE_ASSERT_IMPL(a_pal_range, out_valid, out_word.palette_index <= 3'd5)

    `VVFE_ASSERT_IMPL(a_color_dir, out_valid, ((out_word.face_dir == vvfe_pkg::DIR_XP) && (out_word.face_color == vvfe_pkg::COLOR_XP)) || ((out_word.face_dir == vvfe_pkg::DIR_XN) && (out_word.face_color == vvfe_pkg::COLOR_XN)) || ((out_word.face_dir == vvfe_pkg::DIR_YP) && (out_word.face_color == vvfe_pkg::COLOR_YP)) || ((out_word.face_dir == vvfe_pkg::DIR_YN) && (out_word.face_color == vvfe_pkg::COLOR_YN)) || ((out_word.face_dir == vvfe_pkg::DIR_ZP) && (out_word.face_color == vvfe_pkg::COLOR_ZP)) || ((out_word.face_dir == vvfe_pkg::DIR_ZN) && (out_word.face_color == vvfe_pkg::COLOR_ZN)))

    // records of one query follow each other with no gap, same block, rising dir
    `VVFE_ASSERT_NEXT(a_run_cont, out_valid && !out_stall && !out_word.last, out_valid && (out_word.face_x == $past(out_word.face_x)) && (out_word.face_y == $past(out_word.face_y)) && (out_word.face_z == $past(out_word.face_z)) && (out_word.face_dir > $past(out_word.face_dir)))

endmodule

bind voxel_visible_face_extractor vvfe_checker u_vvfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

`default_nettype wire
